### design/block_buffer_cache_controller_defines.svh
// ----------------------------------------------------------------------------
// Buffer cache controller assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_CONTROLLER_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define BBC_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bbc: assertion failed");
`define BBC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bbc: assertion failed");
`else
`define BBC_ASSERT_IMP(label, cond, prop)
`define BBC_ASSERT_NEXT(label, cond, prop)
`endif

`endif

### design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache controller package
// Shared codes, result record and state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int BUFFER_COUNT_DEF = 16;

  localparam logic [2:0] FUNC_GET        = 3'd0;
  localparam logic [2:0] FUNC_READ       = 3'd1;
  localparam logic [2:0] FUNC_RELEASE    = 3'd2;
  localparam logic [2:0] FUNC_WRITE      = 3'd3;
  localparam logic [2:0] FUNC_FLUSH      = 3'd4;
  localparam logic [2:0] FUNC_READ_AHEAD = 3'd5;

  localparam logic [1:0] KIND_FINAL     = 2'd0;
  localparam logic [1:0] KIND_WRITEBACK = 2'd1;
  localparam logic [1:0] KIND_DEVREAD   = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_NOFREE    = 2'd2;
  localparam logic [1:0] ST_NOTLOCKED = 2'd3;

  localparam int FL_LOCKED = 0;
  localparam int FL_VALID  = 1;
  localparam int FL_DELWRI = 2;
  localparam int FL_TAGGED = 3;

  localparam logic [7:0]  DEV_NONE = 8'hFF;
  localparam logic [31:0] BLK_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {LRU_NOP, LRU_UNLINK, LRU_APPEND, LRU_PREPEND} lru_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_FOUND, S_MISS, S_EV_CHK, S_EV_APP,
    S_AFTER_MAIN, S_RA_DONE, S_RA_REL, S_MAIN_CHK, S_FINAL_OK, S_BI_RD,
    S_BI_CHK, S_REL, S_WFINAL, S_FL_RD, S_FL_CHK, S_FL_UNL, S_FL_APP,
    S_FL_NEXT, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic        hit;
    logic        wv;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [1:0] status,
                                  logic [3:0] slot, logic [7:0] dev,
                                  logic [31:0] blk, logic hit, logic wv,
                                  logic last);
    res_t r;
    r.kind = kind;
    r.status = status;
    r.slot = slot;
    r.dev = dev;
    r.blk = blk;
    r.hit = hit;
    r.wv = wv;
    r.last = last;
    return r;
  endfunction

endpackage

### design/bbc_tag_mem.sv
// ----------------------------------------------------------------------------
// Buffer tag memory
// One write port and one registered read port holding device and block tags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_tag_mem import bbc_pkg::*; #(
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
  localparam int IW = $clog2(BUFFER_COUNT)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [39:0]   wdata,
  input  logic [IW-1:0] raddr,
  output logic [39:0]   rdata
);

  logic [39:0] mem [BUFFER_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/bbc_lru.sv
// ----------------------------------------------------------------------------
// Buffer free list
// LRU ordered list of buffer indices; the first count entries are free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_lru import bbc_pkg::*; #(
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
  localparam int IW = $clog2(BUFFER_COUNT),
  localparam int CW = $clog2(BUFFER_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  lru_op_t       op,
  input  logic [IW-1:0] sel,
  output logic [IW-1:0] head,
  output logic [CW-1:0] count
);

  logic [IW-1:0] order      [BUFFER_COUNT];
  logic [IW-1:0] order_next [BUFFER_COUNT];
  logic [CW-1:0] count_next;
  logic [IW-1:0] pos;
  logic          in_list;

  always_comb begin
    pos = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (order[i] == sel) pos = IW'(i);
    end
  end

  assign in_list = CW'(pos) < count;
  assign head = order[0];

  always_comb begin
    order_next = order;
    count_next = count;
    case (op)
      LRU_UNLINK: begin
        if (in_list) begin
          for (int i = 0; i < BUFFER_COUNT - 1; i++) begin
            if (CW'(i) >= CW'(pos) && CW'(i + 1) < count) order_next[i] = order[i + 1];
          end
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (CW'(i + 1) == count) order_next[i] = sel;
          end
          count_next = count - CW'(1);
        end
      end
      LRU_APPEND: begin
        if (!in_list && count < CW'(BUFFER_COUNT)) begin
          order_next[pos] = order[count[IW-1:0]];
          order_next[count[IW-1:0]] = sel;
          count_next = count + CW'(1);
        end
      end
      LRU_PREPEND: begin
        if (!in_list && count < CW'(BUFFER_COUNT)) begin
          for (int i = 1; i < BUFFER_COUNT; i++) begin
            if (CW'(i) <= CW'(pos)) order_next[i] = order[i - 1];
          end
          order_next[0] = sel;
          count_next = count + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_COUNT; i++) order[i] <= IW'(i);
      count <= CW'(BUFFER_COUNT);
    end else begin
      order <= order_next;
      count <= count_next;
    end
  end

endmodule

### design/block_buffer_cache_controller.sv
// Get and read scan the tag memory buffer by buffer; a device read follows
// when a read finds no valid data, each evicted delayed-write buffer is
// written back first, and a read-ahead adds a second scan. Release and write
// check the lock and update flags and free list; a flush visits every buffer
// and writes back each unlocked delayed one. Throughput: one request at a time.
// Reset: flags clear and the free list returns to ascending order at once.
// ----------------------------------------------------------------------------
// Block buffer cache controller
// Tag lookup, LRU eviction, delayed writes and device flush for a buffer cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_buffer_cache_controller_defines.svh"

module block_buffer_cache_controller import bbc_pkg::*; #(
  parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  dev,
  input  logic [31:0] blkno,
  input  logic [31:0] ahead_blkno,
  input  logic [3:0]  buf_index,
  input  logic        sync,
  input  logic        delayed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [7:0]  out_dev,
  output logic [31:0] out_blkno,
  output logic        hit,
  output logic        was_valid,
  output logic        last
);

  localparam int IW = $clog2(BUFFER_COUNT);
  localparam int CW = $clog2(BUFFER_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_COUNT - 1);

  state_t state, state_next, ret_state, ret_next;

  logic [2:0]  func_r;
  logic [7:0]  dev_r;
  logic [31:0] blk_r, ahead_r;
  logic [3:0]  bi_r;
  logic        sync_r, dl_r;

  logic [31:0]   tgt_blk, tgt_blk_next;
  logic          ra, ra_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] slot_r, slot_next;
  logic          hit_r, hit_next, wv_r, wv_next;
  logic [IW-1:0] ev_slot, ev_slot_next;
  logic [7:0]    tdev, tdev_next;
  logic [31:0]   tblk, tblk_next;
  res_t          res, res_next, out_res;

  logic [3:0]    flags [BUFFER_COUNT];
  logic [IW-1:0] fl_addr;
  logic [3:0]    fl_cur;
  logic          flag_we;
  logic [3:0]    flag_wval;
  logic [BUFFER_COUNT-1:0] locked_vec;

  logic          mem_we;
  logic [IW-1:0] raddr;
  logic [39:0]   rdata;
  logic [7:0]    rd_dev, dev_eff;
  logic [31:0]   rd_blk, blk_eff;

  lru_op_t       lru_op;
  logic [IW-1:0] lru_sel, lru_head;
  logic [CW-1:0] lru_count;

  logic [IW-1:0] bi_idx;
  logic          bi_bad;
  logic          can_emit;
  logic          accept;

  bbc_tag_mem #(.BUFFER_COUNT(BUFFER_COUNT)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ev_slot),
    .wdata ({dev_r, tgt_blk}),
    .raddr (raddr),
    .rdata (rdata)
  );

  bbc_lru #(.BUFFER_COUNT(BUFFER_COUNT)) u_lru (
    .clk   (clk),
    .rst   (rst),
    .op    (lru_op),
    .sel   (lru_sel),
    .head  (lru_head),
    .count (lru_count)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_emit = !out_valid || out_ready;
  assign rd_dev   = rdata[39:32];
  assign rd_blk   = rdata[31:0];
  assign bi_idx   = IW'(bi_r);
  assign bi_bad   = 6'(buf_index) >= 6'(BUFFER_COUNT);

  // A buffer that was never tagged reports DEV_NONE and BLK_NONE, not its unreset tags.
  assign dev_eff = fl_cur[FL_TAGGED] ? rd_dev : DEV_NONE;
  assign blk_eff = fl_cur[FL_TAGGED] ? rd_blk : BLK_NONE;

  always_comb begin
    case (state)
      S_EV_CHK, S_EV_APP, S_RA_DONE, S_RA_REL: fl_addr = ev_slot;
      S_MAIN_CHK: fl_addr = slot_r;
      S_BI_CHK, S_REL: fl_addr = bi_idx;
      default: fl_addr = idx;
    endcase
  end

  assign fl_cur = flags[fl_addr];

  always_comb begin
    for (int i = 0; i < BUFFER_COUNT; i++) locked_vec[i] = flags[i][FL_LOCKED];
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret_state;
    tgt_blk_next = tgt_blk;
    ra_next      = ra;
    idx_next     = idx;
    slot_next    = slot_r;
    hit_next     = hit_r;
    wv_next      = wv_r;
    ev_slot_next = ev_slot;
    tdev_next    = tdev;
    tblk_next    = tblk;
    res_next     = res;
    raddr        = idx;
    mem_we       = 1'b0;
    flag_we      = 1'b0;
    flag_wval    = fl_cur;
    lru_op       = LRU_NOP;
    lru_sel      = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_GET, FUNC_READ, FUNC_READ_AHEAD: begin
              tgt_blk_next = blkno;
              ra_next = 1'b0;
              idx_next = '0;
              state_next = S_SCAN_RD;
            end
            FUNC_RELEASE, FUNC_WRITE: begin
              if (bi_bad) begin
                res_next = mk_res(KIND_FINAL, ST_NOTLOCKED, buf_index, 8'd0, 32'd0,
                                  1'b0, 1'b0, 1'b1);
                ret_next = S_IDLE;
                state_next = S_EMIT;
              end else begin
                state_next = S_BI_RD;
              end
            end
            FUNC_FLUSH: begin
              idx_next = '0;
              state_next = S_FL_RD;
            end
            default: begin
              res_next = mk_res(KIND_FINAL, ST_DONE, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1);
              ret_next = S_IDLE;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        raddr = idx;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (fl_cur[FL_TAGGED] && rd_dev == dev_r && rd_blk == tgt_blk) begin
          state_next = S_FOUND;
        end else if (idx == LAST_IDX) begin
          state_next = S_MISS;
        end else begin
          idx_next = idx + IW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_FOUND: begin
        if (!ra) begin
          hit_next = 1'b1;
          slot_next = idx;
          if (fl_cur[FL_LOCKED]) begin
            res_next = mk_res(KIND_FINAL, ST_BUSY, 4'(idx), dev_r, blk_r, 1'b1, 1'b0, 1'b1);
            ret_next = S_IDLE;
            state_next = S_EMIT;
          end else begin
            lru_op = LRU_UNLINK;
            wv_next = fl_cur[FL_VALID];
            flag_we = 1'b1;
            flag_wval = fl_cur | (4'd1 << FL_LOCKED);
            state_next = S_AFTER_MAIN;
          end
        end else if (fl_cur[FL_VALID] || fl_cur[FL_LOCKED]) begin
          // Read-ahead block already valid or busy: skip it.
          state_next = S_MAIN_CHK;
        end else begin
          lru_op = LRU_UNLINK;
          flag_we = 1'b1;
          flag_wval = fl_cur | (4'd1 << FL_LOCKED);
          ev_slot_next = idx;
          state_next = S_RA_DONE;
        end
      end
      S_MISS: begin
        if (lru_count == '0) begin
          if (ra) begin
            state_next = S_MAIN_CHK;
          end else begin
            hit_next = 1'b0;
            res_next = mk_res(KIND_FINAL, ST_NOFREE, 4'd0, dev_r, blk_r, 1'b0, 1'b0, 1'b1);
            ret_next = S_IDLE;
            state_next = S_EMIT;
          end
        end else begin
          lru_op = LRU_UNLINK;
          lru_sel = lru_head;
          ev_slot_next = lru_head;
          raddr = lru_head;
          state_next = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (fl_cur[FL_DELWRI]) begin
          res_next = mk_res(KIND_WRITEBACK, ST_DONE, 4'(ev_slot), rd_dev, rd_blk,
                            1'b0, 1'b0, 1'b0);
          flag_we = 1'b1;
          flag_wval = fl_cur & ~(4'd1 << FL_DELWRI);
          ret_next = S_EV_APP;
          state_next = S_EMIT;
        end else begin
          mem_we = 1'b1;
          flag_we = 1'b1;
          flag_wval = (4'd1 << FL_LOCKED) | (4'd1 << FL_TAGGED);
          if (ra) begin
            state_next = S_RA_DONE;
          end else begin
            slot_next = ev_slot;
            hit_next = 1'b0;
            wv_next = 1'b0;
            state_next = S_AFTER_MAIN;
          end
        end
      end
      S_EV_APP: begin
        lru_op = LRU_APPEND;
        lru_sel = ev_slot;
        state_next = S_MISS;
      end
      S_AFTER_MAIN: begin
        if (func_r == FUNC_READ_AHEAD && ahead_r != blk_r) begin
          tgt_blk_next = ahead_r;
          ra_next = 1'b1;
          idx_next = '0;
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_MAIN_CHK;
        end
      end
      S_RA_DONE: begin
        // A read-ahead buffer reaching here never holds valid data.
        res_next = mk_res(KIND_DEVREAD, ST_DONE, 4'(ev_slot), dev_r, ahead_r,
                          1'b0, 1'b0, 1'b0);
        flag_we = 1'b1;
        flag_wval = fl_cur | (4'd1 << FL_VALID);
        ret_next = S_RA_REL;
        state_next = S_EMIT;
      end
      S_RA_REL: begin
        lru_op = LRU_APPEND;
        lru_sel = ev_slot;
        flag_we = 1'b1;
        flag_wval = fl_cur & ~(4'd1 << FL_LOCKED);
        state_next = S_MAIN_CHK;
      end
      S_MAIN_CHK: begin
        if (func_r != FUNC_GET && !fl_cur[FL_VALID]) begin
          res_next = mk_res(KIND_DEVREAD, ST_DONE, 4'(slot_r), dev_r, blk_r,
                            1'b0, 1'b0, 1'b0);
          flag_we = 1'b1;
          flag_wval = fl_cur | (4'd1 << FL_VALID);
          ret_next = S_FINAL_OK;
          state_next = S_EMIT;
        end else begin
          state_next = S_FINAL_OK;
        end
      end
      S_FINAL_OK: begin
        res_next = mk_res(KIND_FINAL, ST_DONE, 4'(slot_r), dev_r, blk_r, hit_r, wv_r, 1'b1);
        ret_next = S_IDLE;
        state_next = S_EMIT;
      end
      S_BI_RD: begin
        raddr = bi_idx;
        state_next = S_BI_CHK;
      end
      S_BI_CHK: begin
        tdev_next = dev_eff;
        tblk_next = blk_eff;
        if (!fl_cur[FL_LOCKED]) begin
          res_next = mk_res(KIND_FINAL, ST_NOTLOCKED, bi_r, dev_eff, blk_eff,
                            1'b0, 1'b0, 1'b1);
          ret_next = S_IDLE;
          state_next = S_EMIT;
        end else if (func_r == FUNC_RELEASE) begin
          state_next = S_REL;
        end else if (dl_r) begin
          flag_we = 1'b1;
          flag_wval = fl_cur | (4'd1 << FL_DELWRI);
          state_next = S_REL;
        end else begin
          res_next = mk_res(KIND_WRITEBACK, ST_DONE, bi_r, dev_eff, blk_eff,
                            1'b0, 1'b0, 1'b0);
          flag_we = 1'b1;
          flag_wval = (fl_cur & ~(4'd1 << FL_DELWRI)) | (4'd1 << FL_VALID);
          ret_next = sync_r ? S_REL : S_WFINAL;
          state_next = S_EMIT;
        end
      end
      S_REL: begin
        // Buffers without valid data go to the oldest end for early reuse.
        lru_op = fl_cur[FL_VALID] ? LRU_APPEND : LRU_PREPEND;
        lru_sel = bi_idx;
        flag_we = 1'b1;
        flag_wval = fl_cur & ~(4'd1 << FL_LOCKED);
        state_next = S_WFINAL;
      end
      S_WFINAL: begin
        res_next = mk_res(KIND_FINAL, ST_DONE, bi_r, tdev, tblk, 1'b0, 1'b0, 1'b1);
        ret_next = S_IDLE;
        state_next = S_EMIT;
      end
      S_FL_RD: begin
        raddr = idx;
        state_next = S_FL_CHK;
      end
      S_FL_CHK: begin
        if (rd_dev == dev_r && fl_cur[FL_DELWRI] && !fl_cur[FL_LOCKED]) begin
          res_next = mk_res(KIND_WRITEBACK, ST_DONE, 4'(idx), rd_dev, rd_blk,
                            1'b0, 1'b0, 1'b0);
          flag_we = 1'b1;
          flag_wval = (fl_cur & ~(4'd1 << FL_DELWRI)) | (4'd1 << FL_VALID);
          ret_next = S_FL_UNL;
          state_next = S_EMIT;
        end else begin
          state_next = S_FL_NEXT;
        end
      end
      S_FL_UNL: begin
        lru_op = LRU_UNLINK;
        state_next = S_FL_APP;
      end
      S_FL_APP: begin
        lru_op = LRU_APPEND;
        state_next = S_FL_NEXT;
      end
      S_FL_NEXT: begin
        if (idx == LAST_IDX) begin
          res_next = mk_res(KIND_FINAL, ST_DONE, 4'd0, dev_r, 32'd0, 1'b0, 1'b0, 1'b1);
          ret_next = S_IDLE;
          state_next = S_EMIT;
        end else begin
          idx_next = idx + IW'(1);
          state_next = S_FL_RD;
        end
      end
      S_EMIT: begin
        if (can_emit) state_next = ret_state;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ret_state <= ret_next;
    tgt_blk   <= tgt_blk_next;
    ra        <= ra_next;
    idx       <= idx_next;
    slot_r    <= slot_next;
    hit_r     <= hit_next;
    wv_r      <= wv_next;
    ev_slot   <= ev_slot_next;
    tdev      <= tdev_next;
    tblk      <= tblk_next;
    res       <= res_next;
    if (accept) begin
      func_r  <= func;
      dev_r   <= dev;
      blk_r   <= blkno;
      ahead_r <= ahead_blkno;
      bi_r    <= buf_index;
      sync_r  <= sync;
      dl_r    <= delayed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_COUNT; i++) flags[i] <= 4'd0;
    end else if (flag_we) begin
      flags[fl_addr] <= flag_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && can_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && can_emit) out_res <= res;
  end

  assign kind      = out_res.kind;
  assign status    = out_res.status;
  assign slot      = out_res.slot;
  assign out_dev   = out_res.dev;
  assign out_blkno = out_res.blk;
  assign hit       = out_res.hit;
  assign was_valid = out_res.wv;
  assign last      = out_res.last;

  // Between requests the free list holds exactly the unlocked buffers.
  `BBC_ASSERT_IMP(a_free_matches_locks, state == S_IDLE, lru_count == CW'(BUFFER_COUNT) - CW'($countones(locked_vec)))
  `BBC_ASSERT_NEXT(a_emit_holds, state == S_EMIT && !can_emit, state == S_EMIT)
  `BBC_ASSERT_NEXT(a_accept_leaves_idle, accept, state != S_IDLE)

endmodule
